>>> sv/fgn_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and table functions for the fractal gradient noise block
// no dependencies

package fgn_pkg;

  // default parameter values
  localparam int DEF_MAX_OCTAVES = 16;
  localparam int DEF_COORD_BITS  = 12;
  localparam int DEF_PHASE_BITS  = 10;

  // fixed field widths
  localparam int PIX_W   = 12;
  localparam int SUM_W   = 40;
  localparam int CNT_W   = 6;
  localparam int IDX_W   = 3;
  localparam int CFG_W   = 32;
  localparam int STEP0_W = 24;

  // hash multipliers
  localparam logic [31:0] HASH_M1 = 32'd3284157443;
  localparam logic [31:0] HASH_M2 = 32'd1911520717;
  localparam logic [31:0] HASH_M3 = 32'd2048419325;

  // fixed point constants
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int          Q14_ONE     = 16384;

  // register reset values
  localparam logic [31:0] RST_SEED      = 32'd999999;
  localparam logic [23:0] RST_BASE_STEP = 24'd10486;
  localparam logic [4:0]  RST_OCT_CNT   = 5'd12;
  localparam logic [15:0] RST_AMP       = 16'd24576;
  localparam logic [15:0] RST_GAIN      = 16'd19661;

  // register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_SEED      = 3'd0,
    REG_BASE_STEP = 3'd1,
    REG_OCT_CNT   = 3'd2,
    REG_AMP       = 3'd3,
    REG_GAIN      = 3'd4
  } fgn_reg_t;

  // gradient quadrants
  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } fgn_quad_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } fgn_in_t;

  typedef struct packed {
    logic signed [15:0] noise_value;
    logic [7:0]         shade;
  } fgn_out_t;

  // request travelling along the octave chain
  typedef struct packed {
    logic [PIX_W-1:0]        pixel_x;
    logic [PIX_W-1:0]        pixel_y;
    logic signed [SUM_W-1:0] sum;
  } fgn_item_t;

  // settings every cell reads
  typedef struct packed {
    logic [31:0]      seed;
    logic [15:0]      start_amp;
    logic [CNT_W-1:0] oct_n;
  } fgn_cfg_t;

  function automatic logic [31:0] rot16(input logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

  // q30 to q14 with rounding, limited to [0, one]
  function automatic logic [14:0] q30_to_q14(input logic signed [63:0] v);
    logic signed [63:0] c;
    logic signed [63:0] r;
    c = (v < 0) ? 64'sd0 : v;
    r = (c + 64'sd32768) >>> 16;
    return (r > 64'sd16384) ? 15'd16384 : 15'(r);
  endfunction

  function automatic logic [63:0] quarter_angle(input int r, input int pb);
    return (64'(r) * HALF_PI_Q30) >> (pb - 2);
  endfunction

  // sine of a quarter wave entry, evaluated at elaboration
  function automatic logic [14:0] grad_sin(input int r, input int pb);
    logic [63:0] th;
    logic [63:0] th2;
    logic [63:0] t;
    th  = quarter_angle(r, pb);
    th2 = (th * th) >> 30;
    t = ONE_Q30 - th2 / 72;
    t = ONE_Q30 - ((th2 * t) >> 30) / 42;
    t = ONE_Q30 - ((th2 * t) >> 30) / 20;
    t = ONE_Q30 - ((th2 * t) >> 30) / 6;
    return q30_to_q14($signed((th * t) >> 30));
  endfunction

  // cosine of a quarter wave entry, evaluated at elaboration
  function automatic logic [14:0] grad_cos(input int r, input int pb);
    logic [63:0] th;
    logic [63:0] th2;
    logic [63:0] t;
    th  = quarter_angle(r, pb);
    th2 = (th * th) >> 30;
    t = ONE_Q30 - th2 / 90;
    t = ONE_Q30 - ((th2 * t) >> 30) / 56;
    t = ONE_Q30 - ((th2 * t) >> 30) / 30;
    t = ONE_Q30 - ((th2 * t) >> 30) / 12;
    return q30_to_q14($signed(ONE_Q30) - $signed(((th2 * t) >> 30) / 2));
  endfunction

endpackage

>>> sv/fgn_grad_rom.sv
`timescale 1ns / 1ps
// gradient lookup: angle index to signed q1.14 (sin, cos) pair
// depends on fgn_pkg

module fgn_grad_rom import fgn_pkg::*; #(
  parameter int PHASE_BITS = DEF_PHASE_BITS
) (
  input  logic [PHASE_BITS-1:0] phase,
  output logic signed [15:0]    grad_x,
  output logic signed [15:0]    grad_y
);

  localparam int QN = 1 << (PHASE_BITS - 2);

  logic [14:0]        sin_tab [QN];
  logic [14:0]        cos_tab [QN];
  logic [14:0]        s_w;
  logic [14:0]        c_w;
  logic signed [15:0] sp_w;
  logic signed [15:0] cp_w;

  // constant quarter wave tables
  for (genvar i = 0; i < QN; i++) begin : g_tab
    assign sin_tab[i] = grad_sin(i, PHASE_BITS);
    assign cos_tab[i] = grad_cos(i, PHASE_BITS);
  end

  assign s_w  = sin_tab[phase[PHASE_BITS-3:0]];
  assign c_w  = cos_tab[phase[PHASE_BITS-3:0]];
  assign sp_w = $signed({1'b0, s_w});
  assign cp_w = $signed({1'b0, c_w});

  // quadrant signs
  always_comb begin
    case (fgn_quad_t'(phase[PHASE_BITS-1 -: 2]))
      QUAD_0: begin grad_x = sp_w;  grad_y = cp_w;  end
      QUAD_1: begin grad_x = cp_w;  grad_y = -sp_w; end
      QUAD_2: begin grad_x = -sp_w; grad_y = -cp_w; end
      default: begin grad_x = -cp_w; grad_y = sp_w; end
    endcase
  end

endmodule

>>> sv/fgn_cell.sv
`timescale 1ns / 1ps
// one octave cell: scales the pixel, hashes the four corners, blends and
// adds its weighted term to the running sum; depends on fgn_pkg, fgn_grad_rom

module fgn_cell import fgn_pkg::*; #(
  parameter int OCT_IDX    = 0,
  parameter int STEP_W     = 33,
  parameter int PHASE_BITS = DEF_PHASE_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  fgn_cfg_t          cfg,
  input  logic [STEP_W-1:0] step_in,
  output logic [STEP_W-1:0] step_out,
  input  logic              vld_in,
  input  fgn_item_t         item_in,
  output logic              vld_out,
  output fgn_item_t         item_out
);

  localparam int LAT   = 10;
  localparam int POS_W = PIX_W + STEP_W;

  logic [STEP_W-1:0] step_r;
  logic [LAT-1:0]    vld_r;
  fgn_item_t         dly_r [LAT];

  logic [POS_W-1:0] px_r, py_r;
  logic [63:0]      pxw, pyw;
  logic [31:0]      ix0, iy0;

  logic [31:0] ax_r [2];
  logic [31:0] by_r [2];
  logic [15:0] fx_r, fy_r;
  logic [31:0] ffx_r, ffy_r;

  logic [17:0] wx, wy;
  logic [49:0] smx, smy;
  logic [31:0] b_r [4];
  logic [31:0] a3_r [4];
  logic [16:0] sx3_r, sy3_r;
  logic [15:0] fx3_r, fy3_r;

  logic [31:0] h_r [4];
  logic [16:0] sx4_r, sy4_r;
  logic [15:0] fx4_r, fy4_r;

  logic signed [15:0] gx_w [4];
  logic signed [15:0] gy_w [4];
  logic signed [15:0] gx_r [4];
  logic signed [15:0] gy_r [4];
  logic [16:0]        sx5_r, sy5_r;
  logic [15:0]        fx5_r, fy5_r;

  logic signed [17:0] dx_w [4];
  logic signed [17:0] dy_w [4];
  logic signed [34:0] dsum_w [4];
  logic signed [18:0] n_r [4];
  logic [16:0]        sx6_r, sy6_r;

  logic signed [19:0] dtop_w, dbot_w;
  logic signed [37:0] pt_r, pb_r;
  logic signed [18:0] n0_r, n2_r;
  logic [16:0]        sy7_r;

  logic signed [19:0] top_w, bot_w, top_r;
  logic signed [20:0] dv_w;
  logic signed [38:0] pv_r;

  logic signed [19:0] val_w;
  logic signed [36:0] pa_r;

  logic signed [SUM_W-1:0] term_w;
  logic                    en_w;

  // octave step, settles down the chain after a register write
  always_ff @(posedge clk) begin
    step_r <= step_in;
  end
  assign step_out = STEP_W'(({2'b00, step_r} + {1'b0, step_r, 1'b0}) >> 1);

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], vld_in};
    end
  end

  // lattice cell and fraction
  assign pxw = 64'(px_r);
  assign pyw = 64'(py_r);
  assign ix0 = pxw[55:24];
  assign iy0 = pyw[55:24];

  // smoothstep weights
  assign wx  = 18'd196608 - {1'b0, fx_r, 1'b0};
  assign wy  = 18'd196608 - {1'b0, fy_r, 1'b0};
  assign smx = 50'(ffx_r) * 50'(wx);
  assign smy = 50'(ffy_r) * 50'(wy);

  // corner gradients and dot products
  for (genvar c = 0; c < 4; c++) begin : g_corner
    fgn_grad_rom #(.PHASE_BITS(PHASE_BITS)) u_rom (
      .phase  (h_r[c][31 -: PHASE_BITS]),
      .grad_x (gx_w[c]),
      .grad_y (gy_w[c])
    );
    if (c % 2 == 1) begin : g_dx1
      assign dx_w[c] = $signed({2'b00, fx5_r}) - 18'sd65536;
    end else begin : g_dx0
      assign dx_w[c] = $signed({2'b00, fx5_r});
    end
    if (c / 2 == 1) begin : g_dy1
      assign dy_w[c] = $signed({2'b00, fy5_r}) - 18'sd65536;
    end else begin : g_dy0
      assign dy_w[c] = $signed({2'b00, fy5_r});
    end
    assign dsum_w[c] = 35'(dx_w[c] * gx_r[c]) + 35'(dy_w[c] * gy_r[c]);
  end

  // blends
  assign dtop_w = 20'(n_r[1]) - 20'(n_r[0]);
  assign dbot_w = 20'(n_r[3]) - 20'(n_r[2]);
  assign top_w  = 20'(n0_r) + 20'(pt_r >>> 16);
  assign bot_w  = 20'(n2_r) + 20'(pb_r >>> 16);
  assign dv_w   = 21'(bot_w) - 21'(top_w);
  assign val_w  = top_r + 20'(pv_r >>> 16);

  // octave weight
  assign en_w   = CNT_W'(OCT_IDX) < cfg.oct_n;
  assign term_w = en_w ? SUM_W'(pa_r >>> OCT_IDX) : '0;

  // datapath stages
  always_ff @(posedge clk) begin
    if (adv) begin
      dly_r[0] <= item_in;
      for (int i = 1; i < LAT - 1; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
      dly_r[LAT-1].pixel_x <= dly_r[LAT-2].pixel_x;
      dly_r[LAT-1].pixel_y <= dly_r[LAT-2].pixel_y;
      dly_r[LAT-1].sum     <= dly_r[LAT-2].sum + term_w;

      // scaled position
      px_r <= POS_W'(item_in.pixel_x) * POS_W'(step_r);
      py_r <= POS_W'(item_in.pixel_y) * POS_W'(step_r);

      // first hash round
      ax_r[0] <= (ix0 + cfg.seed) * HASH_M1;
      ax_r[1] <= (ix0 + 32'd1 + cfg.seed) * HASH_M1;
      by_r[0] <= iy0 + cfg.seed;
      by_r[1] <= iy0 + 32'd1 + cfg.seed;
      fx_r    <= px_r[23:8];
      fy_r    <= py_r[23:8];
      ffx_r   <= 32'(px_r[23:8]) * 32'(px_r[23:8]);
      ffy_r   <= 32'(py_r[23:8]) * 32'(py_r[23:8]);

      // second and third hash rounds, gradient and dot product registers
      for (int c = 0; c < 4; c++) begin
        b_r[c]  <= (by_r[c >> 1] ^ rot16(ax_r[c & 1])) * HASH_M2;
        a3_r[c] <= ax_r[c & 1];
        h_r[c]  <= (a3_r[c] ^ rot16(b_r[c])) * HASH_M3;
        gx_r[c] <= gx_w[c];
        gy_r[c] <= gy_w[c];
        n_r[c]  <= 19'(dsum_w[c] >>> 14);
      end
      sx3_r <= smx[48:32];
      sy3_r <= smy[48:32];
      fx3_r <= fx_r;
      fy3_r <= fy_r;
      sx4_r <= sx3_r;
      sy4_r <= sy3_r;
      fx4_r <= fx3_r;
      fy4_r <= fy3_r;
      sx5_r <= sx4_r;
      sy5_r <= sy4_r;
      fx5_r <= fx4_r;
      fy5_r <= fy4_r;
      sx6_r <= sx5_r;
      sy6_r <= sy5_r;

      // horizontal blends
      pt_r  <= dtop_w * $signed({1'b0, sx6_r});
      pb_r  <= dbot_w * $signed({1'b0, sx6_r});
      n0_r  <= n_r[0];
      n2_r  <= n_r[2];
      sy7_r <= sy6_r;

      // vertical blend
      pv_r  <= dv_w * $signed({1'b0, sy7_r});
      top_r <= top_w;

      // amplitude
      pa_r <= val_w * $signed({1'b0, cfg.start_amp});
    end
  end

  assign vld_out  = vld_r[LAT-1];
  assign item_out = dly_r[LAT-1];

endmodule

>>> sv/fgn_out.sv
`timescale 1ns / 1ps
// output stage: gain, saturation, shade and the output register with skid
// depends on fgn_pkg

module fgn_out import fgn_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    vld_in,
  input  logic signed [SUM_W-1:0] sum_in,
  input  logic [15:0]             gain,
  output logic                    adv,
  output logic                    out_valid,
  input  logic                    out_stall,
  output fgn_out_t                out_data
);

  localparam int PROD_W = SUM_W + 17;

  logic                     v1_r, v2_r, out_v_r, skid_v_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [27:0]       v_w;
  logic signed [15:0]       noise_w;
  logic [15:0]              u_w;
  logic [23:0]              sh_w;
  fgn_out_t                 res_r, out_r, skid_r;

  assign adv = !skid_v_r;

  // saturation and shade
  assign v_w = 28'(prod_r >>> 29);
  always_comb begin
    if (v_w > 28'sd16384) begin
      noise_w = 16'(Q14_ONE);
    end else if (v_w < -28'sd16384) begin
      noise_w = -16'(Q14_ONE);
    end else begin
      noise_w = 16'(v_w);
    end
  end
  assign u_w  = 16'(noise_w + 16'(Q14_ONE));
  assign sh_w = {u_w, 8'h00} - 24'(u_w);

  // valid and skid control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!skid_v_r) begin
      v1_r <= vld_in;
      v2_r <= v1_r;
      if (out_v_r && out_stall) begin
        skid_v_r <= v2_r;
      end else begin
        out_v_r <= v2_r;
      end
    end else if (!out_stall) begin
      out_v_r  <= 1'b1;
      skid_v_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (!skid_v_r) begin
      prod_r            <= sum_in * $signed({1'b0, gain});
      res_r.noise_value <= noise_w;
      res_r.shade       <= sh_w[22:15];
      if (out_v_r && out_stall) begin
        skid_r <= res_r;
      end else begin
        out_r <= res_r;
      end
    end else if (!out_stall) begin
      out_r <= skid_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r) else $error("skid holds a request with output empty");

  a_noise_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_r.noise_value <= 16'sd16384) && (out_r.noise_value >= -16'sd16384))
    else $error("noise value outside unit range");

  a_zero_shade: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_r.noise_value == 16'sd0) |-> out_r.shade == 8'd127)
    else $error("zero noise gives wrong shade");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !out_stall |=> !skid_v_r) else $error("skid not drained");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_v_r && !skid_v_r) else $error("output valid after reset");

endmodule

>>> sv/fractal_gradient_noise_pixel.sv
`timescale 1ns / 1ps
// fractal gradient noise per pixel: one pixel request per clock while the output skid is empty;
// each pixel passes the ten-stage octave cells in series plus the gain and output stages.
// reset: registers take their default values and the pipeline empties at once;
// a base step write reaches later octave cells through each cell's step register.

module fractal_gradient_noise_pixel import fgn_pkg::*; #(
  parameter int MAX_OCTAVES = DEF_MAX_OCTAVES,
  parameter int COORD_BITS  = DEF_COORD_BITS,
  parameter int PHASE_BITS  = DEF_PHASE_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  fgn_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output fgn_out_t         out_data,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int STEP_W = STEP0_W + ((MAX_OCTAVES - 1) * 585 + 999) / 1000;
  localparam logic [PIX_W-1:0] PIX_MASK =
    (COORD_BITS >= PIX_W) ? {PIX_W{1'b1}} : PIX_W'((1 << COORD_BITS) - 1);

  logic [31:0]      seed_r;
  logic [23:0]      base_step_r;
  logic [4:0]       oct_cnt_r;
  logic [15:0]      amp_r;
  logic [15:0]      gain_r;
  logic             adv;
  fgn_cfg_t         cfg;
  logic [STEP_W-1:0] step_c [MAX_OCTAVES+1];
  logic             vld_c  [MAX_OCTAVES+1];
  fgn_item_t        item_c [MAX_OCTAVES+1];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= RST_SEED;
      base_step_r <= RST_BASE_STEP;
      oct_cnt_r   <= RST_OCT_CNT;
      amp_r       <= RST_AMP;
      gain_r      <= RST_GAIN;
    end else if (cfg_we) begin
      unique case (fgn_reg_t'(cfg_index))
        REG_SEED:      seed_r      <= cfg_wdata;
        REG_BASE_STEP: base_step_r <= cfg_wdata[23:0];
        REG_OCT_CNT:   oct_cnt_r   <= cfg_wdata[4:0];
        REG_AMP:       amp_r       <= cfg_wdata[15:0];
        REG_GAIN:      gain_r      <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // settings seen by the cells, octave count limited to the chain length
  assign cfg.seed      = seed_r;
  assign cfg.start_amp = amp_r;
  assign cfg.oct_n     = (CNT_W'(oct_cnt_r) > CNT_W'(MAX_OCTAVES)) ?
                         CNT_W'(MAX_OCTAVES) : CNT_W'(oct_cnt_r);

  // chain head
  assign in_stall        = !adv;
  assign step_c[0]       = STEP_W'(base_step_r);
  assign vld_c[0]        = in_valid;
  assign item_c[0].pixel_x = in_data.pixel_x & PIX_MASK;
  assign item_c[0].pixel_y = in_data.pixel_y & PIX_MASK;
  assign item_c[0].sum     = '0;

  // octave cells
  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
    fgn_cell #(
      .OCT_IDX    (k),
      .STEP_W     (STEP_W),
      .PHASE_BITS (PHASE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cfg      (cfg),
      .step_in  (step_c[k]),
      .step_out (step_c[k+1]),
      .vld_in   (vld_c[k]),
      .item_in  (item_c[k]),
      .vld_out  (vld_c[k+1]),
      .item_out (item_c[k+1])
    );
  end

  // gain, saturation and output register
  fgn_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .vld_in    (vld_c[MAX_OCTAVES]),
    .sum_in    (item_c[MAX_OCTAVES].sum),
    .gain      (gain_r),
    .adv       (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
